// File: rtl/ecpr_pkg.sv
// Shared constants, types and helper functions for the clock page replacer.
package ecpr_pkg;

    localparam int NUM_FRAMES = 4;
    localparam int PAGE_BITS  = 16;

    localparam int IDX_W      = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam int CNT_W      = $clog2(NUM_FRAMES + 1);
    localparam int IN_PAGE_W  = 16;
    localparam int OUT_PAGE_W = 16;
    localparam int OUT_SLOT_W = 2;

    typedef logic [PAGE_BITS-1:0] t_page;
    typedef logic [IDX_W-1:0]     t_idx;
    typedef logic [CNT_W-1:0]     t_cnt;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_COMPARE,
        ST_SWEEP,
        ST_EVICT
    } t_state;

    typedef struct packed {
        logic cap;
        logic look_next;
        logic hit;
        logic fill;
        logic sweep_step;
        logic victim_rd;
        logic evict;
    } t_cmd;

    typedef struct packed {
        logic match;
        logic look_last;
        logic full;
        logic victim;
    } t_status;

    function automatic t_page to_page(input logic [IN_PAGE_W-1:0] value);
        logic [IN_PAGE_W+PAGE_BITS-1:0] wide;
        wide = {{PAGE_BITS{1'b0}}, value};
        return wide[PAGE_BITS-1:0];
    endfunction

    function automatic logic [OUT_PAGE_W-1:0] to_out_page(input t_page value);
        logic [OUT_PAGE_W+PAGE_BITS-1:0] wide;
        wide = {{OUT_PAGE_W{1'b0}}, value};
        return wide[OUT_PAGE_W-1:0];
    endfunction

    function automatic logic [OUT_SLOT_W-1:0] to_out_slot(input t_idx value);
        logic [OUT_SLOT_W+IDX_W-1:0] wide;
        wide = {{OUT_SLOT_W{1'b0}}, value};
        return wide[OUT_SLOT_W-1:0];
    endfunction

endpackage

// File: rtl/ecpr_ctrl.sv
// Sequencer for lookup, fill and victim search of the clock page replacer.
module ecpr_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  ecpr_pkg::t_status i_status,
    output ecpr_pkg::t_cmd   o_cmd,
    output logic             busy
);

    ecpr_pkg::t_state r_state;
    ecpr_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ecpr_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ecpr_pkg::ST_IDLE: begin
                if (start) begin
                    o_cmd.cap = 1'b1;
                    n_state   = ecpr_pkg::ST_READ;
                end
            end
            ecpr_pkg::ST_READ: begin
                n_state = ecpr_pkg::ST_COMPARE;
            end
            ecpr_pkg::ST_COMPARE: begin
                if (i_status.match) begin
                    o_cmd.hit = 1'b1;
                    n_state   = ecpr_pkg::ST_IDLE;
                end else if (i_status.look_last) begin
                    if (!i_status.full) begin
                        o_cmd.fill = 1'b1;
                        n_state    = ecpr_pkg::ST_IDLE;
                    end else begin
                        n_state = ecpr_pkg::ST_SWEEP;
                    end
                end else begin
                    o_cmd.look_next = 1'b1;
                    n_state         = ecpr_pkg::ST_READ;
                end
            end
            ecpr_pkg::ST_SWEEP: begin
                if (i_status.victim) begin
                    o_cmd.victim_rd = 1'b1;
                    n_state         = ecpr_pkg::ST_EVICT;
                end else begin
                    o_cmd.sweep_step = 1'b1;
                end
            end
            ecpr_pkg::ST_EVICT: begin
                o_cmd.evict = 1'b1;
                n_state     = ecpr_pkg::ST_IDLE;
            end
            default: begin
                n_state = ecpr_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy = (r_state != ecpr_pkg::ST_IDLE);

endmodule

// File: rtl/ecpr_datapath.sv
// Frame store, reference and modify bits, clock hand and result registers.
module ecpr_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [ecpr_pkg::IN_PAGE_W-1:0]    i_page_id,
    input  ecpr_pkg::t_cmd                    i_cmd,
    output ecpr_pkg::t_status                 o_status,
    output logic                              o_done,
    output logic                              o_hit,
    output logic [ecpr_pkg::OUT_SLOT_W-1:0]   o_frame_slot,
    output logic                              o_evicted_valid,
    output logic [ecpr_pkg::OUT_PAGE_W-1:0]   o_evicted_page
);

    // Frame store: one write port, one registered read port.
    ecpr_pkg::t_page mem [ecpr_pkg::NUM_FRAMES];
    ecpr_pkg::t_page r_rd_data;

    ecpr_pkg::t_page                     r_page;
    logic [ecpr_pkg::NUM_FRAMES-1:0]     r_ref;
    logic [ecpr_pkg::NUM_FRAMES-1:0]     r_mod;
    ecpr_pkg::t_idx                      r_hand;
    ecpr_pkg::t_cnt                      r_filled;
    ecpr_pkg::t_idx                      r_idx;
    ecpr_pkg::t_idx                      r_sweep_cnt;
    logic                                r_phase;
    ecpr_pkg::t_idx                      r_slot;
    logic                                r_done;
    logic                                r_hit;
    logic                                r_ev_valid;
    logic [ecpr_pkg::OUT_PAGE_W-1:0]     r_ev_page;

    ecpr_pkg::t_idx  rd_addr;
    ecpr_pkg::t_idx  wr_addr;
    logic            wr_en;
    ecpr_pkg::t_idx  hand_next;
    ecpr_pkg::t_cnt  idx_ext;
    logic            hand_cond;

    assign rd_addr   = i_cmd.victim_rd ? r_hand : r_idx;
    assign wr_en     = i_cmd.fill | i_cmd.evict;
    assign wr_addr   = i_cmd.evict ? r_slot : r_filled[ecpr_pkg::IDX_W-1:0];
    assign hand_next = (r_hand == ecpr_pkg::IDX_W'(ecpr_pkg::NUM_FRAMES - 1))
                       ? '0 : r_hand + 1'b1;
    assign idx_ext   = ecpr_pkg::CNT_W'(r_idx);

    // The first sweep wants a clean unreferenced frame, the second a dirty one.
    assign hand_cond = !r_ref[r_hand] && (r_mod[r_hand] == r_phase);

    assign o_status.match     = (idx_ext < r_filled) && (r_rd_data == r_page);
    assign o_status.look_last = ((idx_ext + 1'b1) >= r_filled);
    assign o_status.full      = (r_filled == ecpr_pkg::CNT_W'(ecpr_pkg::NUM_FRAMES));
    assign o_status.victim    = hand_cond;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= r_page;
        end
        r_rd_data <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref       <= '0;
            r_mod       <= '0;
            r_hand      <= '0;
            r_filled    <= '0;
            r_idx       <= '0;
            r_sweep_cnt <= '0;
            r_phase     <= 1'b0;
            r_done      <= 1'b0;
        end else begin
            r_done <= i_cmd.hit | i_cmd.fill | i_cmd.evict;
            if (i_cmd.cap) begin
                r_idx       <= '0;
                r_sweep_cnt <= '0;
                r_phase     <= 1'b0;
            end
            if (i_cmd.look_next) begin
                r_idx <= r_idx + 1'b1;
            end
            if (i_cmd.hit) begin
                r_ref[r_idx] <= 1'b1;
            end
            if (i_cmd.fill) begin
                r_ref[r_filled[ecpr_pkg::IDX_W-1:0]] <= 1'b1;
                r_mod[r_filled[ecpr_pkg::IDX_W-1:0]] <= 1'b0;
                r_filled <= r_filled + 1'b1;
            end
            if (i_cmd.sweep_step) begin
                r_hand <= hand_next;
                if (r_phase) begin
                    r_ref[r_hand] <= 1'b0;
                end
                if (r_sweep_cnt == ecpr_pkg::IDX_W'(ecpr_pkg::NUM_FRAMES - 1)) begin
                    r_sweep_cnt <= '0;
                    r_phase     <= ~r_phase;
                end else begin
                    r_sweep_cnt <= r_sweep_cnt + 1'b1;
                end
            end
            if (i_cmd.victim_rd) begin
                r_hand <= hand_next;
            end
            if (i_cmd.evict) begin
                r_ref[r_slot] <= 1'b1;
                r_mod[r_slot] <= 1'b1;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_page <= ecpr_pkg::to_page(i_page_id);
        end
        if (i_cmd.hit) begin
            r_slot     <= r_idx;
            r_hit      <= 1'b1;
            r_ev_valid <= 1'b0;
            r_ev_page  <= '0;
        end
        if (i_cmd.fill) begin
            r_slot     <= r_filled[ecpr_pkg::IDX_W-1:0];
            r_hit      <= 1'b0;
            r_ev_valid <= 1'b0;
            r_ev_page  <= '0;
        end
        if (i_cmd.victim_rd) begin
            r_slot <= r_hand;
        end
        if (i_cmd.evict) begin
            r_hit      <= 1'b0;
            r_ev_valid <= 1'b1;
            r_ev_page  <= ecpr_pkg::to_out_page(r_rd_data);
        end
    end

    assign o_done          = r_done;
    assign o_hit           = r_hit;
    assign o_frame_slot    = ecpr_pkg::to_out_slot(r_slot);
    assign o_evicted_valid = r_ev_valid;
    assign o_evicted_page  = r_ev_page;

    // The fill count never passes the number of frames.
    a_filled_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_filled <= ecpr_pkg::CNT_W'(ecpr_pkg::NUM_FRAMES))
        else $error("fill count beyond frame count");

    // Victim search only runs with every frame filled.
    a_sweep_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.sweep_step || i_cmd.victim_rd) |-> o_status.full)
        else $error("victim search with free frames");

    // A page placed by an eviction is marked referenced and modified.
    a_evict_ref: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.evict |=> r_ref[$past(r_slot)] && r_mod[$past(r_slot)])
        else $error("evicted frame not marked referenced and modified");

endmodule

// File: rtl/enhanced_clock_page_replacer_top.sv
// Top level of the enhanced second-chance clock page replacer.
//
// One page request is transferred at a rising edge where start is high and
// busy is low; i_page_id is sampled at that edge. busy stays high while the
// request is worked on and drops in the cycle that the result is shown.
// The result appears on o_hit, o_frame_slot, o_evicted_valid and
// o_evicted_page for exactly one cycle, marked by o_done, and is transferred
// at the edge ending that cycle. The receiver cannot stall, so no result is
// ever held back; a new request may be started while o_done is high.
// Sequence: the frame store has a registered read port, so the lookup reads
// and then compares each filled frame in turn, stopping at the first match,
// and still reads and compares frame zero when no frame is filled yet. A miss
// with a free frame finishes at the last compare. A miss with every frame
// filled then moves the clock hand one frame per step (at most three sweeps
// over all frames) and afterwards reads out and replaces the victim. The
// next request can be transferred at the edge that ends the result cycle.
// Reset (synchronous, active low) empties all frames, clears the reference
// and modify bits and parks the clock hand at frame zero; no clearing pass
// over the frame store is needed because unfilled frames are never compared.
module enhanced_clock_page_replacer_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    input  logic [ecpr_pkg::IN_PAGE_W-1:0]  i_page_id,
    output logic                            busy,
    output logic                            o_done,
    output logic                            o_hit,
    output logic [ecpr_pkg::OUT_SLOT_W-1:0] o_frame_slot,
    output logic                            o_evicted_valid,
    output logic [ecpr_pkg::OUT_PAGE_W-1:0] o_evicted_page
);

    ecpr_pkg::t_cmd    cmd;
    ecpr_pkg::t_status status;

    // The controller sequences lookup, fill and victim search.
    ecpr_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_status (status),
        .o_cmd    (cmd),
        .busy     (busy)
    );

    // The datapath holds the frames, their bits, the hand and the result.
    ecpr_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_page_id       (i_page_id),
        .i_cmd           (cmd),
        .o_status        (status),
        .o_done          (o_done),
        .o_hit           (o_hit),
        .o_frame_slot    (o_frame_slot),
        .o_evicted_valid (o_evicted_valid),
        .o_evicted_page  (o_evicted_page)
    );

    // A hit never evicts anything.
    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_hit) |-> !o_evicted_valid)
        else $error("hit reported with eviction");

    // Without an eviction the evicted page reads as zero.
    a_no_evict_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_evicted_valid) |-> (o_evicted_page == '0))
        else $error("evicted page nonzero without eviction");

    // A result only follows a cycle in which a request was in progress.
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result without a request in progress");

    // An accepted request raises busy in the next cycle.
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

endmodule
